@@ sv/ddjm_pkg.sv @@
// Package for the differential drive joystick mixer.
// Holds the transaction payload types, direction codes and fixed-point constants.
// No dependencies.
`default_nettype none

package ddjm_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = FRAC_BITS / DIV_STAGES;
    localparam int MIX_SHIFT      = FRAC_BITS + 7;

    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    localparam logic [6:0] DUTY_MAX = 7'd100;

    localparam logic CFG_PIVOT_LIMIT    = 1'b0;
    localparam logic CFG_TURN_THRESHOLD = 1'b1;

    typedef struct packed {
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
    } stick_in_t;

    typedef struct packed {
        logic [1:0]        left_dir;
        logic [6:0]        left_duty;
        logic [1:0]        right_dir;
        logic [6:0]        right_duty;
        logic signed [7:0] mix_left;
        logic signed [7:0] mix_right;
    } mix_out_t;

    typedef struct packed {
        logic [1:0] left_dir;
        logic [6:0] left_duty;
        logic [1:0] right_dir;
        logic [6:0] right_duty;
    } motor_cmd_t;

endpackage

`default_nettype wire

@@ sv/differential_drive_joystick_mixer.sv @@
// Throughput: one transaction per cycle while m_ready does not stall the output;
// nine register stages with per-stage valid bits, the pivot-weight divide by
// pivot_limit is spread over four of them.
// Reset (aresetn low, synchronous) empties the pipeline and loads
// pivot_limit = 32 and turn_threshold = 40.
`default_nettype none

module differential_drive_joystick_mixer
    import ddjm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_addr,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire stick_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output mix_out_t        m_data
);

    localparam int NSTAGE  = DIV_STAGES + 5;
    localparam int LAST    = NSTAGE - 1;
    localparam int MUL1_ST = DIV_STAGES + 1;
    localparam int MUL2_ST = DIV_STAGES + 2;
    localparam int SUM_ST  = DIV_STAGES + 3;

    typedef struct packed {
        motor_cmd_t             cmd;
        logic signed [7:0]      x;
        logic signed [7:0]      y;
        logic signed [7:0]      pl;
        logic signed [7:0]      pr;
        logic                   full;
        logic [6:0]             rem;
        logic [FRAC_BITS-1:0]   q;
    } div_t;

    typedef struct packed {
        motor_cmd_t         cmd;
        logic signed [7:0]  y;
        logic signed [24:0] wpl;
        logic signed [24:0] wpr;
        logic signed [24:0] sx;
    } mul1_t;

    typedef struct packed {
        motor_cmd_t         cmd;
        logic signed [31:0] wply;
        logic signed [31:0] wpry;
        logic signed [31:0] sx128;
    } mul2_t;

    typedef struct packed {
        motor_cmd_t         cmd;
        logic signed [32:0] nl;
        logic signed [32:0] nr;
    } sum_t;

    function automatic div_t div_step(div_t d, logic [6:0] lim);
        div_t       r;
        logic [7:0] r2;
        r = d;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            r2 = {r.rem, 1'b0};
            if (r2 >= {1'b0, lim}) begin
                r.rem = 7'(r2 - {1'b0, lim});
                r.q   = {r.q[FRAC_BITS-2:0], 1'b1};
            end else begin
                r.rem = r2[6:0];
                r.q   = {r.q[FRAC_BITS-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic signed [7:0] mix_round(logic signed [32:0] n);
        logic signed [32:0] t;
        logic signed [9:0]  v;
        // bias negatives so the shift truncates toward zero
        t = n[32] ? (n + 33'((34'd1 << MIX_SHIFT) - 34'd1)) : n;
        v = t[32:MIX_SHIFT];
        if (v > 10'sd127) begin
            return 8'sd127;
        end else if (v < -10'sd128) begin
            return -8'sd128;
        end else begin
            return v[7:0];
        end
    endfunction

    logic [6:0]        pivot_limit_reg;
    logic [7:0]        turn_threshold_reg;
    logic [LAST:0]     vld_reg;
    logic [LAST:0]     stage_rdy;

    div_t              div_reg [DIV_STAGES+1];
    div_t              div_next;
    mul1_t             mul1_reg;
    mul1_t             mul1_next;
    mul2_t             mul2_reg;
    mul2_t             mul2_next;
    sum_t              sum_reg;
    sum_t              sum_next;
    mix_out_t          out_reg;
    mix_out_t          out_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pivot_limit_reg    <= 7'd32;
            turn_threshold_reg <= 8'd40;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_PIVOT_LIMIT:    pivot_limit_reg    <= cfg_wdata[6:0];
                CFG_TURN_THRESHOLD: turn_threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or its successor moves
    always_comb begin
        stage_rdy[LAST] = !vld_reg[LAST] || m_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            stage_rdy[k] = !vld_reg[k] || stage_rdy[k+1];
        end
    end

    assign s_ready = stage_rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stage_rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (stage_rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // entry stage: direction, duty, premix and divide setup
    always_comb begin
        logic signed [7:0] x;
        logic signed [7:0] y;
        logic [7:0]        ax;
        logic [7:0]        ay;
        logic              low_y;
        logic [6:0]        duty_x;
        logic [6:0]        duty_y;
        x      = s_data.stick_x;
        y      = s_data.stick_y;
        ax     = x[7] ? 8'(-x) : 8'(x);
        ay     = y[7] ? 8'(-y) : 8'(y);
        low_y  = ay < turn_threshold_reg;
        duty_x = (ax > {1'b0, DUTY_MAX}) ? DUTY_MAX : ax[6:0];
        duty_y = (ay > {1'b0, DUTY_MAX}) ? DUTY_MAX : ay[6:0];

        div_next = '0;
        div_next.x = x;
        div_next.y = y;
        div_next.cmd.left_dir   = DIR_STOP;
        div_next.cmd.right_dir  = DIR_STOP;
        div_next.cmd.left_duty  = '0;
        div_next.cmd.right_duty = '0;
        if (x == 8'sd0 && y == 8'sd0) begin
            div_next.cmd.left_dir = DIR_STOP;
        end else if (!x[7] && x != 8'sd0 && low_y) begin
            div_next.cmd = '{DIR_FWD, duty_x, DIR_FWD, duty_x};
        end else if (x[7] && low_y) begin
            div_next.cmd = '{DIR_BACK, duty_x, DIR_BACK, duty_x};
        end else if (!y[7] && y != 8'sd0) begin
            div_next.cmd = '{DIR_BACK, duty_y, DIR_FWD, duty_y};
        end else if (y[7]) begin
            div_next.cmd = '{DIR_FWD, duty_y, DIR_BACK, duty_y};
        end

        if (!y[7]) begin
            div_next.pl = x[7] ? (8'sd127 + x) : 8'sd127;
            div_next.pr = x[7] ? 8'sd127 : (8'sd127 - x);
        end else begin
            div_next.pl = x[7] ? 8'sd127 : (8'sd127 - x);
            div_next.pr = x[7] ? (8'sd127 + x) : 8'sd127;
        end

        // full weight when blending is off or |y| reaches the limit
        div_next.full = (pivot_limit_reg == 7'd0) || (ay >= {1'b0, pivot_limit_reg});
        div_next.rem  = ay[6:0];
        div_next.q    = '0;
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[0] && s_valid) begin
            div_reg[0] <= div_next;
        end
        for (int k = 1; k <= DIV_STAGES; k++) begin
            if (stage_rdy[k] && vld_reg[k-1]) begin
                div_reg[k] <= div_step(div_reg[k-1], pivot_limit_reg);
            end
        end
    end

    // weight times premix, pivot weight times x
    always_comb begin
        div_t              d;
        logic [FRAC_BITS:0] w;
        logic [FRAC_BITS:0] s;
        d = div_reg[DIV_STAGES];
        w = d.full ? FRAC_ONE : {1'b0, d.q};
        s = d.full ? '0 : (FRAC_ONE - {1'b0, d.q});
        mul1_next.cmd = d.cmd;
        mul1_next.y   = d.y;
        mul1_next.wpl = $signed({8'b0, w}) * $signed({{17{d.pl[7]}}, d.pl});
        mul1_next.wpr = $signed({8'b0, w}) * $signed({{17{d.pr[7]}}, d.pr});
        mul1_next.sx  = $signed({8'b0, s}) * $signed({{17{d.x[7]}}, d.x});
    end

    always_comb begin
        mul2_next.cmd   = mul1_reg.cmd;
        mul2_next.wply  = $signed({{7{mul1_reg.wpl[24]}}, mul1_reg.wpl})
                        * $signed({{24{mul1_reg.y[7]}}, mul1_reg.y});
        mul2_next.wpry  = $signed({{7{mul1_reg.wpr[24]}}, mul1_reg.wpr})
                        * $signed({{24{mul1_reg.y[7]}}, mul1_reg.y});
        mul2_next.sx128 = {mul1_reg.sx, 7'b0};
    end

    always_comb begin
        sum_next.cmd = mul2_reg.cmd;
        sum_next.nl  = {mul2_reg.wply[31], mul2_reg.wply}
                     + {mul2_reg.sx128[31], mul2_reg.sx128};
        sum_next.nr  = {mul2_reg.wpry[31], mul2_reg.wpry}
                     - {mul2_reg.sx128[31], mul2_reg.sx128};
    end

    always_comb begin
        out_next.left_dir   = sum_reg.cmd.left_dir;
        out_next.left_duty  = sum_reg.cmd.left_duty;
        out_next.right_dir  = sum_reg.cmd.right_dir;
        out_next.right_duty = sum_reg.cmd.right_duty;
        out_next.mix_left   = mix_round(sum_reg.nl);
        out_next.mix_right  = mix_round(sum_reg.nr);
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[MUL1_ST] && vld_reg[MUL1_ST-1]) begin
            mul1_reg <= mul1_next;
        end
        if (stage_rdy[MUL2_ST] && vld_reg[MUL2_ST-1]) begin
            mul2_reg <= mul2_next;
        end
        if (stage_rdy[SUM_ST] && vld_reg[SUM_ST-1]) begin
            sum_reg <= sum_next;
        end
        if (stage_rdy[LAST] && vld_reg[LAST-1]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vld_reg[LAST];
    assign m_data  = out_reg;

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.left_duty <= DUTY_MAX && m_data.right_duty <= DUTY_MAX))
        else $error("duty above saturation limit");

    a_dir_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.left_dir != 2'd3 && m_data.right_dir != 2'd3))
        else $error("undefined direction code");

    a_stop_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.left_dir == DIR_STOP) |->
        (m_data.left_duty == 7'd0 && m_data.right_dir == DIR_STOP))
        else $error("stop command with nonzero duty");

    a_stall_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[LAST] && !m_ready && vld_reg[LAST-1]) |=> vld_reg[LAST-1])
        else $error("transaction dropped behind stalled output");

endmodule

`default_nettype wire

@@ bench/tb_differential_drive_joystick_mixer.sv @@
// Self-checking bench for the differential drive joystick mixer.
// Predicts motor commands and steering mix per stick sample and scoreboards them.
// Depends on ddjm_pkg and differential_drive_joystick_mixer.
`default_nettype none

module tb_differential_drive_joystick_mixer
    import ddjm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    PIPE_DRAIN   = 12;
    localparam int    CYCLE_LIMIT  = 400000;
    localparam int    CHUNK_ITEMS  = 250;
    localparam int    CHUNKS       = 8;
    localparam int    MAX_REPORTS  = 10;
    localparam longint WEIGHT_ONE  = longint'(1) << FRAC_BITS;
    localparam longint MIX_DIVISOR = longint'(1) << MIX_SHIFT;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_addr;
    logic [7:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    stick_in_t  s_data;
    logic       m_valid;
    logic       m_ready;
    mix_out_t   m_data;

    // bench copy of the block's registers
    logic [6:0] pivot_lim;
    logic [7:0] turn_thr;

    stick_in_t stick_queue[$];
    mix_out_t  expected_mix[$];

    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  err_count;
    int  results_checked;
    int  settings_run;
    int  cycle_count;
    bit  s_fire;

    differential_drive_joystick_mixer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] clamp_mix(input longint num);
        longint v;
        v = num / MIX_DIVISOR;
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        return v[7:0];
    endfunction

    function automatic mix_out_t predict_mix(input stick_in_t smp, input logic [6:0] pl,
                                             input logic [7:0] tt);
        mix_out_t r;
        int       x, y, ax, ay, duty;
        longint   p_l, p_r, w, s;
        logic     low_y;
        x = int'($signed(smp.stick_x));
        y = int'($signed(smp.stick_y));
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        low_y = ay < int'(tt);
        r = '0;
        r.left_dir  = DIR_STOP;
        r.right_dir = DIR_STOP;
        duty = 0;
        if (x == 0 && y == 0) begin
            duty = 0;
        end else if (x > 0 && low_y) begin
            r.left_dir = DIR_FWD;  r.right_dir = DIR_FWD;  duty = ax;
        end else if (x < 0 && low_y) begin
            r.left_dir = DIR_BACK; r.right_dir = DIR_BACK; duty = ax;
        end else if (y > 0) begin
            r.left_dir = DIR_BACK; r.right_dir = DIR_FWD;  duty = ay;
        end else if (y < 0) begin
            r.left_dir = DIR_FWD;  r.right_dir = DIR_BACK; duty = ay;
        end
        // no rule matched above leaves both motors stopped
        if (duty > int'(DUTY_MAX)) duty = int'(DUTY_MAX);
        r.left_duty  = duty[6:0];
        r.right_duty = duty[6:0];

        // drive premix; the sides swap when backing up
        if (y >= 0) begin
            p_l = x >= 0 ? 127 : 127 + x;
            p_r = x >= 0 ? 127 - x : 127;
        end else begin
            p_l = x >= 0 ? 127 - x : 127;
            p_r = x >= 0 ? 127 : 127 + x;
        end

        if (pl == 0 || ay > int'(pl))
            w = WEIGHT_ONE;
        else
            w = (longint'(ay) * WEIGHT_ONE) / longint'(pl);
        s = WEIGHT_ONE - w;

        r.mix_left  = clamp_mix(w * p_l * y + s * x * 128);
        r.mix_right = clamp_mix(w * p_r * y - s * x * 128);
        return r;
    endfunction

    // mostly uniform, with a share of values sitting on the register boundaries
    function automatic logic [7:0] pick_axis(input int pl, input int tt);
        int v;
        case ($urandom_range(0, 9))
            7: begin
                case ($urandom_range(0, 3))
                    0: v = -128;
                    1: v = 127;
                    2: v = 0;
                    default: v = ($urandom_range(0, 1) != 0) ? 1 : -1;
                endcase
            end
            8: v = tt + $urandom_range(0, 2) - 1;
            9: v = pl + $urandom_range(0, 2) - 1;
            default: v = int'($urandom_range(0, 255));
        endcase
        if (v != -128 && $urandom_range(0, 3) == 0) v = -v;
        return v[7:0];
    endfunction

    task automatic push_stick(input int x, input int y);
        stick_in_t smp;
        smp.stick_x = x[7:0];
        smp.stick_y = y[7:0];
        stick_queue.push_back(smp);
    endtask

    // hold off until the pipeline has emptied, then let it settle
    task automatic wait_drained();
        do @(posedge aclk);
        while (stick_queue.size() != 0 || s_valid || expected_mix.size() != 0);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    // both registers, back to back, with the block idle
    task automatic write_config(input logic [7:0] pl_data, input logic [7:0] tt_data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_PIVOT_LIMIT;
        cfg_wdata <= pl_data;
        @(negedge aclk);
        cfg_addr  <= CFG_TURN_THRESHOLD;
        cfg_wdata <= tt_data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        pivot_lim = pl_data[6:0];
        turn_thr  = tt_data;
        settings_run++;
    endtask

    // driver: present the next pending transaction at the falling edge
    always @(negedge aclk) begin
        bit give;
        if (!s_valid || s_fire) begin
            give = stick_queue.size() != 0 &&
                   $urandom_range(0, 99) >= sender_idle_pct;
            if (give) s_data <= stick_queue.pop_front();
            s_valid <= give;
        end
        m_ready <= $urandom_range(0, 99) >= receiver_idle_pct;
    end

    // monitor: predict on input transactions, check on output transactions
    always @(posedge aclk) begin
        mix_out_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_mix.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        s_fire = aresetn && s_valid && s_ready;
        if (s_fire)
            expected_mix.push_back(predict_mix(s_data, pivot_lim, turn_thr));
        if (aresetn && m_valid && m_ready) begin
            if (expected_mix.size() == 0) begin
                if (err_count < MAX_REPORTS)
                    $display("unexpected result transaction %p", m_data);
                err_count++;
            end else begin
                want = expected_mix.pop_front();
                results_checked++;
                if (m_data !== want) begin
                    if (err_count < MAX_REPORTS) begin
                        $display("mismatch at result %0d: expected dir %0d/%0d duty %0d/%0d mix %0d/%0d",
                                 results_checked,
                                 want.left_dir, want.right_dir,
                                 want.left_duty, want.right_duty,
                                 want.mix_left, want.mix_right);
                        $display("    actual dir %0d/%0d duty %0d/%0d mix %0d/%0d",
                                 m_data.left_dir, m_data.right_dir,
                                 m_data.left_duty, m_data.right_duty,
                                 m_data.mix_left, m_data.mix_right);
                    end
                    err_count++;
                end
            end
        end
    end

    initial begin
        logic [7:0] pl_data [CHUNKS];
        logic [7:0] tt_data [CHUNKS];
        int         pl_val;
        int         tt_val;

        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_addr          = CFG_PIVOT_LIMIT;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_data            = '0;
        m_ready           = 1'b0;
        s_fire            = 1'b0;
        pivot_lim         = 7'd32;
        turn_thr          = 8'd40;
        sender_idle_pct   = 38;
        receiver_idle_pct = 63;
        err_count         = 0;
        results_checked   = 0;
        settings_run      = 1;
        cycle_count       = 0;

        pl_data = '{8'd32, 8'd1, 8'd127, 8'd0, 8'd64, 8'h9F, 8'd0, 8'd0};
        tt_data = '{8'd40, 8'd0, 8'd128, 8'd255, 8'd20, 8'd129, 8'd0, 8'd0};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: axis extremes, threshold and pivot edges, duty clip
        push_stick(0, 0);       push_stick(127, 0);    push_stick(-128, 0);
        push_stick(1, 0);       push_stick(-1, 0);     push_stick(0, 127);
        push_stick(0, -128);    push_stick(127, 127);  push_stick(-128, -128);
        push_stick(127, -128);  push_stick(-128, 127); push_stick(50, 39);
        push_stick(-50, -40);   push_stick(101, 10);   push_stick(0, 32);
        push_stick(-7, 33);     push_stick(-128, 5);
        wait_drained();

        // zero threshold with y at zero, and the pivot blend switched off
        write_config(8'd0, 8'd0);
        push_stick(5, 0);  push_stick(-5, 0);  push_stick(-128, 0);  push_stick(20, -20);
        wait_drained();

        // pivot limit 1 once the upper write bit is masked off, threshold beyond any |y|
        write_config(8'h81, 8'd255);
        push_stick(3, -128);  push_stick(-3, 1);  push_stick(0, 1);  push_stick(-128, 127);
        wait_drained();

        for (int c = 0; c < CHUNKS; c++) begin
            if (c < 3) begin
                sender_idle_pct = 38;  receiver_idle_pct = 63;
            end else if (c < 6) begin
                sender_idle_pct = 63;  receiver_idle_pct = 38;
            end else begin
                sender_idle_pct = 0;   receiver_idle_pct = 0;
            end
            if (c >= 6) begin
                pl_data[c] = 8'($urandom_range(0, 255));
                tt_data[c] = 8'($urandom_range(0, 255));
            end
            write_config(pl_data[c], tt_data[c]);
            pl_val = int'(pivot_lim);
            tt_val = int'(turn_thr);
            for (int i = 0; i < CHUNK_ITEMS; i++) begin
                stick_in_t smp;
                smp.stick_x = pick_axis(pl_val, tt_val);
                smp.stick_y = pick_axis(pl_val, tt_val);
                stick_queue.push_back(smp);
            end
            // stall the sender until every outstanding result is back
            wait_drained();
        end

        if (expected_mix.size() != 0) begin
            $display("%0d expected results never arrived", expected_mix.size());
            err_count += expected_mix.size();
        end
        $display("checked %0d results across %0d register settings, %0d mismatches",
                 results_checked, settings_run, err_count);
        $display("covered both idle mixes, free-running flow and drained pauses");
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
